### rtl/core/bbr_pkg.sv
// ---------------------------------------------------------------------------
// bbr_pkg
// Shared types and constants for the Burgers BTCS residual/relax core.
// ---------------------------------------------------------------------------
package bbr_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int MAX_POINTS  = 1024;
    localparam int VAL_W       = 32;
    localparam int IDX_W       = 10;
    localparam int COUNT_W     = $clog2(MAX_POINTS);
    localparam int SAT_W       = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int QUEUE_DEPTH = 2;

    localparam int COEF_W  = 31;
    localparam int DIAG_W  = 17;
    localparam int CFG_W   = 31;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [63:0] SAT_MAX  = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_MIN  = -SAT_MAX - 64'sd1;
    localparam logic signed [63:0] Q_ONE    = 64'sd65536;
    localparam logic signed [63:0] Q_HALF   = 64'sd32768;
    localparam int                 Q_FRAC   = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_G     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAG_INV   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELAX_MODE = 2'd3;

    typedef struct packed {
        logic signed [VAL_W-1:0] cur_value;
        logic signed [VAL_W-1:0] prev_value;
        logic                    prev_present;
        logic signed [VAL_W-1:0] init_value;
        logic                    init_active;
        logic signed [VAL_W-1:0] rhs_value;
        logic                    last_point;
    } item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_value;
        logic [IDX_W-1:0]        point_index;
        logic                    last_result;
    } result_t;

    typedef struct packed {
        logic [COEF_W-1:0] coef_b;
        logic [COEF_W-1:0] coef_g;
        logic [DIAG_W-1:0] diag_inverse;
        logic              relax_mode;
    } cfg_t;

    // one stencil evaluation handed from front to back
    typedef struct packed {
        logic signed [VAL_W-1:0] left_value;
        logic signed [VAL_W-1:0] right_value;
        logic signed [VAL_W-1:0] center_value;
        logic signed [VAL_W-1:0] center_prev;
        logic signed [VAL_W-1:0] center_init;
        logic signed [VAL_W-1:0] center_rhs;
        logic                    prev_present;
        logic                    init_active;
        logic [IDX_W-1:0]        point_index;
        logic                    last_result;
    } job_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } queue_ctl_t;

endpackage

### rtl/core/bbr_job_queue.sv
// ---------------------------------------------------------------------------
// bbr_job_queue
// Short register queue of stencil jobs between the front and the back.
// ---------------------------------------------------------------------------
module bbr_job_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bbr_pkg::job_t     push_job,
    input  logic              pop,
    output bbr_pkg::job_t     head_job,
    output logic              full,
    output logic              empty
);
    import bbr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(QUEUE_DEPTH - 1);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == DEPTH_C);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_P) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_P) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/core/bbr_front.sv
// ---------------------------------------------------------------------------
// bbr_front
// Takes grid point words, keeps the three-point window and issues jobs.
// ---------------------------------------------------------------------------
module bbr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  bbr_pkg::item_t    item,
    input  logic              queue_full,
    output logic              job_push,
    output bbr_pkg::job_t     job
);
    import bbr_pkg::*;

    localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(MAX_POINTS - 1);

    logic signed [VAL_W-1:0] left_reg;
    item_t                   center_reg;
    logic                    center_valid_reg;
    logic [COUNT_W-1:0]      count_reg;
    logic                    pending_reg;   // tail job of a last point still owed
    logic                    accept;
    logic                    tail_push;
    logic [COUNT_W-1:0]      center_idx;

    assign item_ready = !pending_reg && !queue_full;
    assign accept     = item_valid && item_ready;
    assign tail_push  = pending_reg && !queue_full;
    assign job_push   = (accept && center_valid_reg) || tail_push;

    // index of the held center point
    assign center_idx = (count_reg == '0) ? COUNT_LAST : count_reg - 1'b1;

    always_comb
    begin
        job.left_value   = left_reg;
        job.right_value  = pending_reg ? '0 : item.cur_value;
        job.center_value = center_reg.cur_value;
        job.center_prev  = center_reg.prev_value;
        job.center_init  = center_reg.init_value;
        job.center_rhs   = center_reg.rhs_value;
        job.prev_present = center_reg.prev_present;
        job.init_active  = center_reg.init_active;
        job.point_index  = IDX_W'(center_idx);
        job.last_result  = pending_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg         <= '0;
            center_reg       <= '0;
            center_valid_reg <= 1'b0;
            count_reg        <= '0;
            pending_reg      <= 1'b0;
        end
        else if (accept)
        begin
            left_reg         <= center_valid_reg ? center_reg.cur_value : '0;
            center_reg       <= item;
            center_valid_reg <= 1'b1;
            count_reg        <= (count_reg == COUNT_LAST) ? '0 : count_reg + 1'b1;
            pending_reg      <= item.last_point;
        end
        else if (tail_push)
        begin
            // slice done, window empties
            left_reg         <= '0;
            center_reg       <= '0;
            center_valid_reg <= 1'b0;
            count_reg        <= '0;
            pending_reg      <= 1'b0;
        end
    end

endmodule

### rtl/core/bbr_back.sv
// ---------------------------------------------------------------------------
// bbr_back
// Evaluates one stencil job through a shared 32x32 multiplier and holds
// the finished word in the output register.
// ---------------------------------------------------------------------------
module bbr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  bbr_pkg::cfg_t     cfg,
    input  logic              queue_empty,
    input  bbr_pkg::job_t     head_job,
    output logic              job_pop,
    output logic              result_valid,
    input  logic              result_ready,
    output bbr_pkg::result_t  result
);
    import bbr_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE, B_MDC, B_MBS, B_MGP, B_RT3, B_MT4, B_AT4,
        B_SP, B_SI, B_SR, B_MDR, B_RLX, B_OUT
    } back_state_t;

    function automatic logic signed [VAL_W-1:0] sat(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (v > SAT_MAX)
        begin
            r = SAT_MAX;
        end
        else if (v < SAT_MIN)
        begin
            r = SAT_MIN;
        end
        else
        begin
            r = v;
        end
        return r[VAL_W-1:0];
    endfunction

    // round half up, floor shift, saturate
    function automatic logic signed [VAL_W-1:0] qsat(input logic signed [63:0] p);
        logic signed [63:0] q;
        q = (p + Q_HALF) >>> Q_FRAC;
        return sat(q);
    endfunction

    back_state_t             state_reg;
    job_t                    job_reg;
    logic signed [VAL_W-1:0] sum_reg;
    logic signed [VAL_W-1:0] diff_reg;
    logic signed [VAL_W-1:0] acc_reg;
    logic signed [VAL_W-1:0] t_reg;
    logic signed [63:0]      prod_reg;
    logic                    result_valid_reg;
    result_t                 result_reg;

    logic signed [VAL_W-1:0] diag_one;
    logic signed [VAL_W-1:0] mul_a;
    logic signed [VAL_W-1:0] mul_b;
    logic signed [63:0]      mul_p;
    logic                    out_free;

    assign diag_one = sat(Q_ONE + (64'(cfg.coef_b) <<< 1));
    assign job_pop  = (state_reg == B_IDLE) && !queue_empty;
    assign out_free = !result_valid_reg || result_ready;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            B_MDC:
            begin
                mul_a = diag_one;
                mul_b = job_reg.center_value;
            end
            B_MBS:
            begin
                mul_a = $signed(VAL_W'(cfg.coef_b));
                mul_b = sum_reg;
            end
            B_MGP:
            begin
                mul_a = $signed(VAL_W'(cfg.coef_g));
                mul_b = job_reg.center_prev;
            end
            B_MT4:
            begin
                mul_a = t_reg;
                mul_b = diff_reg;
            end
            B_MDR:
            begin
                mul_a = $signed(VAL_W'(cfg.diag_inverse));
                mul_b = acc_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_IDLE;
            result_valid_reg <= 1'b0;
            job_reg          <= '0;
            sum_reg          <= '0;
            diff_reg         <= '0;
            acc_reg          <= '0;
            t_reg            <= '0;
            prod_reg         <= '0;
            result_reg       <= '0;
        end
        else
        begin
            if ((state_reg == B_OUT) && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!queue_empty)
                    begin
                        job_reg   <= head_job;
                        sum_reg   <= sat(64'(head_job.left_value) + 64'(head_job.right_value));
                        diff_reg  <= sat(64'(head_job.right_value) - 64'(head_job.left_value));
                        state_reg <= B_MDC;
                    end
                end
                B_MDC:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= B_MBS;
                end
                B_MBS:
                begin
                    acc_reg   <= qsat(prod_reg);
                    prod_reg  <= mul_p;
                    state_reg <= B_MGP;
                end
                B_MGP:
                begin
                    acc_reg   <= sat(64'(acc_reg) - 64'(qsat(prod_reg)));
                    prod_reg  <= mul_p;
                    state_reg <= B_RT3;
                end
                B_RT3:
                begin
                    t_reg     <= qsat(prod_reg);
                    state_reg <= B_MT4;
                end
                B_MT4:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= B_AT4;
                end
                B_AT4:
                begin
                    acc_reg   <= sat(64'(acc_reg) + 64'(qsat(prod_reg)));
                    state_reg <= B_SP;
                end
                B_SP:
                begin
                    if (job_reg.prev_present)
                    begin
                        acc_reg <= sat(64'(acc_reg) - 64'(job_reg.center_prev));
                    end
                    state_reg <= B_SI;
                end
                B_SI:
                begin
                    if (job_reg.init_active)
                    begin
                        acc_reg <= sat(64'(acc_reg) - 64'(job_reg.center_init));
                    end
                    state_reg <= B_SR;
                end
                B_SR:
                begin
                    acc_reg   <= sat(64'(acc_reg) - 64'(job_reg.center_rhs));
                    state_reg <= cfg.relax_mode ? B_MDR : B_OUT;
                end
                B_MDR:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= B_RLX;
                end
                B_RLX:
                begin
                    acc_reg   <= sat(64'(job_reg.center_value) - 64'(qsat(prod_reg)));
                    state_reg <= B_OUT;
                end
                B_OUT:
                begin
                    if (out_free)
                    begin
                        result_reg.result_value <= acc_reg;
                        result_reg.point_index  <= job_reg.point_index;
                        result_reg.last_result  <= job_reg.last_result;
                        state_reg               <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/core/burgers_btcs_residual_relax_core.sv
// ---------------------------------------------------------------------------
// burgers_btcs_residual_relax_core
// Streaming BTCS stencil residual / point relaxation for viscous Burgers,
// signed Q16.16 with saturation, Dirichlet zero at both slice ends.
// ---------------------------------------------------------------------------
//  channel   signals                              word
//  item      item_valid / item_ready / item       one grid point
//  result    result_valid / result_ready / result one residual or relaxed value
//  cfg       cfg_wr_en / cfg_index / cfg_wr_data  coef_b, coef_g, diag_inverse,
//                                                 relax_mode
//
//  a point is answered when its right neighbor arrives; a last point is
//  answered right after the held point, by a tail job the front pushes alone
//  each result runs the back's state sequence through its single 32x32
//  multiplier, with the B_MDR and B_RLX steps added in relax mode
//  a two-entry job queue lets the front keep taking words while results stall
//  rst_n is asynchronous active low and clears window, queue and output
// ---------------------------------------------------------------------------
module burgers_btcs_residual_relax_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  bbr_pkg::item_t                       item,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output bbr_pkg::result_t                     result,
    input  logic                                 cfg_wr_en,
    input  logic [bbr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bbr_pkg::CFG_W-1:0]            cfg_wr_data
);
    import bbr_pkg::*;

    cfg_t       cfg_reg;
    job_t       front_job;
    job_t       head_job;
    queue_ctl_t qctl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coef_b       <= '0;
            cfg_reg.coef_g       <= '0;
            cfg_reg.diag_inverse <= DIAG_W'(Q_ONE);
            cfg_reg.relax_mode   <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_COEF_B:     cfg_reg.coef_b       <= cfg_wr_data[COEF_W-1:0];
                CFG_COEF_G:     cfg_reg.coef_g       <= cfg_wr_data[COEF_W-1:0];
                CFG_DIAG_INV:   cfg_reg.diag_inverse <= cfg_wr_data[DIAG_W-1:0];
                CFG_RELAX_MODE: cfg_reg.relax_mode   <= cfg_wr_data[0];
                default:        cfg_reg              <= cfg_reg;
            endcase
        end
    end

    bbr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .queue_full (qctl.full),
        .job_push   (qctl.push),
        .job        (front_job)
    );

    bbr_job_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (qctl.push),
        .push_job (front_job),
        .pop      (qctl.pop),
        .head_job (head_job),
        .full     (qctl.full),
        .empty    (qctl.empty)
    );

    bbr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .queue_empty  (qctl.empty),
        .head_job     (head_job),
        .job_pop      (qctl.pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### rtl/core/bbr_checker.sv
// ---------------------------------------------------------------------------
// bbr_checker
// Port-level checks for the residual/relax core, bound to the top level.
// ---------------------------------------------------------------------------
module bbr_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    input  logic                                 item_ready,
    input  bbr_pkg::item_t                       item,
    input  logic                                 result_valid,
    input  logic                                 result_ready,
    input  bbr_pkg::result_t                     result,
    input  logic                                 cfg_wr_en,
    input  logic [bbr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bbr_pkg::CFG_W-1:0]            cfg_wr_data
);
    import bbr_pkg::*;

    logic [IDX_W-1:0] expect_idx_reg;

    // points of a slice are answered in order, restarting after a last word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_idx_reg <= '0;
        end
        else if (result_valid && result_ready)
        begin
            expect_idx_reg <= result.last_result ? '0 : result.point_index + 1'b1;
        end
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed or dropped while stalled");

    a_reset_state: assert property (@(posedge clk)
        !rst_n |=> !result_valid && item_ready)
        else $error("core not empty and ready after reset");

    a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.point_index == expect_idx_reg)
        else $error("result point index out of order");

    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid && $stable(item))
        else $error("item word changed or dropped while waiting");

    a_cfg_known: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |-> !$isunknown({cfg_index, cfg_wr_data}))
        else $error("config write with unknown index or data");

endmodule

bind burgers_btcs_residual_relax_core bbr_checker u_bbr_checker (.*);

### dv/tb_burgers_btcs_residual_relax_core.sv
// ---------------------------------------------------------------------------
// tb_burgers_btcs_residual_relax_core
// Streams grid-point slices into the stencil core under random stalls on both
// channels and compares every result word against a cycle-free predictor of
// the three-point window, with saturating Q16.16 arithmetic.
// ---------------------------------------------------------------------------
module tb_burgers_btcs_residual_relax_core;

    timeunit 1ns;
    timeprecision 1ps;

    import bbr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int REPORT_MAX     = 10;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    logic                 item_ready;
    item_t                item         = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    result_t              result;
    logic                 cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = CFG_COEF_B;
    logic [CFG_W-1:0]     cfg_wr_data  = '0;

    // predictor copy of the registers
    logic [COEF_W-1:0] diff_num = '0;
    logic [COEF_W-1:0] adv_fac  = '0;
    logic [DIAG_W-1:0] diag_inv = DIAG_W'(65536);
    logic              relax_on = 1'b0;

    // predictor copy of the window
    longint           win_left, win_center, win_prev, win_init, win_rhs;
    bit               win_prev_on, win_init_on, win_held;
    logic [IDX_W-1:0] win_count = '0;

    result_t results_due[$];
    int      errors      = 0;
    int      idle_cycles = 0;
    int      hold_left   = 0;
    bit      send_idle   = 1'b1;
    bit      recv_idle   = 1'b1;

    burgers_btcs_residual_relax_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint clamp_sat(longint v);
        if (v > SAT_MAX)
            return SAT_MAX;
        if (v < SAT_MIN)
            return SAT_MIN;
        return v;
    endfunction

    // exact product, +half then floor shift, saturated
    function automatic longint q_mul(longint a, longint b);
        longint p;
        p = a * b + Q_HALF;
        return clamp_sat(p >>> Q_FRAC);
    endfunction

    function automatic longint stencil_value(longint l, longint rt);
        longint bq, gq, d, r;
        bq = longint'(diff_num);
        gq = longint'(adv_fac);
        d  = clamp_sat(Q_ONE + 2 * bq);
        r  = clamp_sat(q_mul(d, win_center) - q_mul(bq, clamp_sat(l + rt)));
        r  = clamp_sat(r + q_mul(q_mul(gq, win_prev), clamp_sat(rt - l)));
        if (win_prev_on)
            r = clamp_sat(r - win_prev);
        if (win_init_on)
            r = clamp_sat(r - win_init);
        r = clamp_sat(r - win_rhs);
        if (relax_on)
            r = clamp_sat(win_center - q_mul(longint'(diag_inv), r));
        return r;
    endfunction

    function automatic result_t make_result(longint v, logic [IDX_W-1:0] idx,
                                            bit last);
        result_t r;
        r.result_value = v[VAL_W-1:0];
        r.point_index  = idx;
        r.last_result  = last;
        return r;
    endfunction

    task automatic advance_window(item_t w);
        longint           cur;
        logic [IDX_W-1:0] idx;
        cur = longint'(w.cur_value);
        if (win_held)
        begin
            idx = win_count - 1'b1;
            results_due.push_back(make_result(stencil_value(win_left, cur), idx, 1'b0));
            win_left = win_center;
        end
        else
        begin
            win_left = 0;
        end
        win_center  = cur;
        win_prev    = longint'(w.prev_value);
        win_init    = longint'(w.init_value);
        win_rhs     = longint'(w.rhs_value);
        win_prev_on = w.prev_present;
        win_init_on = w.init_active;
        win_held    = 1'b1;
        win_count   = win_count + 1'b1;
        // last point: answered right after the held one, then the window empties
        if (w.last_point)
        begin
            idx = win_count - 1'b1;
            results_due.push_back(make_result(stencil_value(win_left, 0), idx, 1'b1));
            win_left    = 0;
            win_center  = 0;
            win_prev    = 0;
            win_init    = 0;
            win_rhs     = 0;
            win_prev_on = 1'b0;
            win_init_on = 1'b0;
            win_held    = 1'b0;
            win_count   = '0;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return $urandom;
        if (r < 32)
        begin
            case ($urandom_range(0, 4))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                3: return 32'hFFFF_FFFF;
                default: return 32'h0000_0001;
            endcase
        end
        // mostly within +-8.0 so the stencil stays out of saturation
        return int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endfunction

    function automatic item_t grid_point(logic [31:0] cur, logic [31:0] prev, bit pp,
                                         logic [31:0] init, bit ia, logic [31:0] rhs,
                                         bit last);
        item_t w;
        w.cur_value    = cur;
        w.prev_value   = prev;
        w.prev_present = pp;
        w.init_value   = init;
        w.init_active  = ia;
        w.rhs_value    = rhs;
        w.last_point   = last;
        return w;
    endfunction

    function automatic item_t random_point(bit last);
        item_t w;
        w.cur_value    = pick_value();
        w.prev_value   = pick_value();
        w.prev_present = 1'($urandom_range(0, 1));
        w.init_value   = pick_value();
        w.init_active  = 1'($urandom_range(0, 1));
        w.rhs_value    = ($urandom_range(0, 99) < 30) ? '0 : pick_value();
        w.last_point   = last;
        return w;
    endfunction

    task automatic send_point(item_t w);
        int gap;
        @(negedge clk);
        item_valid <= 1'b1;
        item       <= w;
        do
            @(posedge clk);
        while (!item_ready);
        advance_window(w);
        gap = send_idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // wait until every due word is back, then let the back end go quiet
    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_config(logic [COEF_W-1:0] b, logic [COEF_W-1:0] g,
                               logic [DIAG_W-1:0] d, bit relax);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_COEF_B;
        cfg_wr_data <= CFG_W'(b);
        @(negedge clk);
        cfg_index   <= CFG_COEF_G;
        cfg_wr_data <= CFG_W'(g);
        @(negedge clk);
        cfg_index   <= CFG_DIAG_INV;
        cfg_wr_data <= CFG_W'(d);
        @(negedge clk);
        cfg_index   <= CFG_RELAX_MODE;
        cfg_wr_data <= CFG_W'(relax);
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        diff_num = b;
        adv_fac  = g;
        diag_inv = d;
        relax_on = relax;
    endtask

    task automatic random_slices(int count);
        int sent, len;
        sent = 0;
        while (sent < count)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: len = $urandom_range(1, 4);
                5, 6, 7, 8:    len = $urandom_range(5, 16);
                default:       len = $urandom_range(17, 60);
            endcase
            if (len > count - sent)
                len = count - sent;
            for (int i = 0; i < len; i++)
                send_point(random_point(i == len - 1));
            sent += len;
        end
    endtask

    // registers still at reset: only the center term and the subtracted terms act
    task automatic test_reset_defaults();
        send_point(grid_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 1'b1,
                              32'h8000_0000, 1'b1));
        send_point(grid_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 1'b0,
                              32'h7FFF_FFFF, 1'b0));
        send_point(grid_point(32'h0001_0000, 32'h0000_8000, 1'b0, 32'hFFFF_0000, 1'b1,
                              32'h0000_0000, 1'b1));
        send_point(grid_point(32'h0002_0000, 32'h0001_0000, 1'b0, 32'h0003_0000, 1'b0,
                              32'h0000_4000, 1'b0));
        send_point(grid_point(32'hFFFE_0000, 32'hFFFF_0000, 1'b1, 32'h0001_0000, 1'b1,
                              32'hFFFF_C000, 1'b0));
        send_point(grid_point(32'h0000_0000, 32'h0002_0000, 1'b0, 32'h0000_0000, 1'b0,
                              32'h0001_0000, 1'b1));
        settle();
    endtask

    task automatic test_saturation_extremes();
        load_config(31'h7FFF_FFFF, 31'h7FFF_FFFF, DIAG_W'(65536), 1'b0);
        send_point(grid_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 1'b1,
                              32'h8000_0000, 1'b0));
        send_point(grid_point(32'h8000_0000, 32'h8000_0000, 1'b0, 32'h7FFF_FFFF, 1'b1,
                              32'h7FFF_FFFF, 1'b0));
        send_point(grid_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h0000_0000, 1'b0,
                              32'h8000_0000, 1'b1));
        settle();
        // zero inverse in relax mode passes the center straight through
        load_config('0, '0, '0, 1'b1);
        send_point(grid_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b1,
                              32'h7FFF_FFFF, 1'b0));
        send_point(grid_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b1,
                              32'h8000_0000, 1'b1));
        settle();
    endtask

    // half-LSB products land exactly on the rounding tie, both signs
    task automatic test_rounding_ties();
        load_config(31'h0000_8000, 31'h0000_8000, DIAG_W'(32'h8000), 1'b1);
        send_point(grid_point(32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h0000_0001, 1'b0,
                              32'h0000_0000, 1'b0));
        send_point(grid_point(32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 32'h0000_0001, 1'b1,
                              32'h0000_0001, 1'b0));
        send_point(grid_point(32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'hFFFF_FFFF, 1'b1,
                              32'h0000_0000, 1'b0));
        send_point(grid_point(32'h0000_0001, 32'h0000_0003, 1'b0, 32'h0000_0000, 1'b0,
                              32'hFFFF_FFFF, 1'b1));
        settle();
    endtask

    // one slice longer than the point counter, so the index wraps
    task automatic test_point_index_wrap();
        load_config(31'h0000_1000, 31'h0000_0800, DIAG_W'(60000), 1'b0);
        for (int i = 0; i < MAX_POINTS + 6; i++)
            send_point(random_point(i == MAX_POINTS + 5));
        settle();
    endtask

    task automatic test_random_residual();
        load_config(31'h0000_4000, 31'h0000_8000, DIAG_W'(43691), 1'b0);
        random_slices(180);
        settle();
    endtask

    task automatic test_random_relax();
        load_config(31'h0000_4000, 31'h0000_8000, DIAG_W'(43691), 1'b1);
        random_slices(180);
        settle();
    endtask

    task automatic test_random_wide_coefs();
        load_config(COEF_W'($urandom), COEF_W'($urandom), DIAG_W'($urandom_range(0, 65536)),
                    1'($urandom_range(0, 1)));
        random_slices(120);
        settle();
    endtask

    task automatic test_random_saturating();
        load_config(31'h7FFF_FFFF, '0, DIAG_W'(65536), 1'b1);
        random_slices(80);
        settle();
    endtask

    task automatic test_random_back_to_back();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        load_config(COEF_W'($urandom_range(0, 32'h4_0000)),
                    COEF_W'($urandom_range(0, 32'h1_0000)),
                    DIAG_W'($urandom_range(0, 65536)), 1'b1);
        random_slices(150);
        settle();
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    always @(negedge clk)
    begin
        if (!recv_idle)
            result_ready <= 1'b1;
        else if (hold_left > 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else
        begin
            hold_left = pick_gap();
            if (hold_left == 0)
                result_ready <= 1'b1;
            else
            begin
                result_ready <= 1'b0;
                hold_left--;
            end
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (results_due.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected word: value %h idx %0d last %0b",
                             result.result_value, result.point_index, result.last_result);
            end
            else
            begin
                want = results_due.pop_front();
                if (result.result_value !== want.result_value ||
                    result.point_index !== want.point_index ||
                    result.last_result !== want.last_result)
                begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display({"mismatch: exp value %h idx %0d last %0b, ",
                                  "got value %h idx %0d last %0b"},
                                 want.result_value, want.point_index, want.last_result,
                                 result.result_value, result.point_index, result.last_result);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_saturation_extremes();
        test_rounding_ties();
        test_point_index_wrap();
        test_random_residual();
        test_random_relax();
        test_random_wide_coefs();
        test_random_saturating();
        test_random_back_to_back();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
